// ----- rtl/core/bcc_pkg.sv -----
// Package for the button click classifier: types, codes and register reset values.
package bcc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned AGE_W      = 16;
    localparam int unsigned DT_W       = 16;
    localparam int unsigned DEB_W      = 8;
    localparam int unsigned CODE_W     = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_TIME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SUPER_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SHORT_EN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SUPER_EN   = 3'd5;

    // Register reset values
    localparam logic [DEB_W-1:0] RST_DEBOUNCE   = 8'd20;
    localparam logic [AGE_W-1:0] RST_LONG_TIME  = 16'd400;
    localparam logic [AGE_W-1:0] RST_SUPER_TIME = 16'd2000;
    localparam logic             RST_SHORT_EN   = 1'b1;
    localparam logic             RST_LONG_EN    = 1'b0;
    localparam logic             RST_SUPER_EN   = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        FIRED_NONE  = 2'd0,
        FIRED_LONG  = 2'd1,
        FIRED_SUPER = 2'd2
    } t_fired;

    typedef enum logic [CODE_W-1:0] {
        CODE_NONE      = 3'd0,
        CODE_QUICK     = 3'd1,
        CODE_LONG      = 3'd2,
        CODE_SUPER     = 3'd3,
        CODE_HELD      = 3'd4,
        CODE_SHORT     = 3'd5,
        CODE_NOT_SHORT = 3'd6
    } t_code;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_time;
        logic [AGE_W-1:0] long_press_time;
        logic [AGE_W-1:0] super_long_press_time;
        logic             short_enable;
        logic             long_enable;
        logic             super_long_enable;
    } t_cfg;

endpackage

// ----- rtl/core/button_click_classifier_top.sv -----
// Top level of the button click classifier: scan input register, classifier, result register.
//
// Takes one scan word per clock while codes are taken, and returns exactly one click
// code per scan, in order. A word passes through the input register and then the
// result register, which is loaded as the press state (phase, age, last timed
// click) updates. While a finished code waits on the output, the input register
// takes one more word and then the input stalls until the code is taken.
// Configuration registers are written through the plain write port and take
// effect on the next scan; write them only while the block holds no words.
module button_click_classifier_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_pressed,
    input  logic [bcc_pkg::DT_W-1:0]       i_elapsed,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bcc_pkg::CODE_W-1:0]     o_click_code
);
    import bcc_pkg::*;

    t_cfg              cfg;
    t_code             code;
    logic              advance;

    logic              r_in_valid;
    logic              r_pressed;
    logic [DT_W-1:0]   r_elapsed;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_click_code;

    bcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bcc_classify u_classify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_pressed (r_pressed),
        .i_elapsed (r_elapsed),
        .i_cfg     (cfg),
        .o_code    (code)
    );

    // Move the held word on when the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_pressed <= i_pressed;
            r_elapsed <= i_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_click_code <= code;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_click_code = r_click_code;

endmodule

// ----- rtl/core/bcc_cfg.sv -----
// Configuration register bank of the button click classifier.
module bcc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output bcc_pkg::t_cfg                  o_cfg
);
    import bcc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_DEBOUNCE:   n_cfg.debounce_time         = i_cfg_wdata[DEB_W-1:0];
                CFG_IDX_LONG_TIME:  n_cfg.long_press_time       = i_cfg_wdata[AGE_W-1:0];
                CFG_IDX_SUPER_TIME: n_cfg.super_long_press_time = i_cfg_wdata[AGE_W-1:0];
                CFG_IDX_SHORT_EN:   n_cfg.short_enable          = i_cfg_wdata[0];
                CFG_IDX_LONG_EN:    n_cfg.long_enable           = i_cfg_wdata[0];
                CFG_IDX_SUPER_EN:   n_cfg.super_long_enable     = i_cfg_wdata[0];
                default:            n_cfg = r_cfg; // drop writes beyond the bank
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time         <= RST_DEBOUNCE;
            r_cfg.long_press_time       <= RST_LONG_TIME;
            r_cfg.super_long_press_time <= RST_SUPER_TIME;
            r_cfg.short_enable          <= RST_SHORT_EN;
            r_cfg.long_enable           <= RST_LONG_EN;
            r_cfg.super_long_enable     <= RST_SUPER_EN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/bcc_classify.sv -----
// Press state machine and click classification for one scan word.
module bcc_classify (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_pressed,
    input  logic [bcc_pkg::DT_W-1:0]  i_elapsed,
    input  bcc_pkg::t_cfg             i_cfg,
    output bcc_pkg::t_code            o_code
);
    import bcc_pkg::*;

    t_phase           r_phase;
    t_phase           n_phase;
    logic [AGE_W-1:0] r_age;
    logic [AGE_W-1:0] n_age;
    t_fired           r_fired;
    t_fired           n_fired;

    logic [AGE_W:0]   age_sum;
    logic [AGE_W-1:0] age_adv;
    logic             quick;

    // Saturating advance of the age
    assign age_sum = {1'b0, r_age} + {1'b0, i_elapsed};
    assign age_adv = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];
    assign quick   = i_cfg.short_enable && !i_cfg.long_enable && !i_cfg.super_long_enable;

    always_comb begin
        n_phase = r_phase;
        n_age   = r_age;
        n_fired = r_fired;
        o_code  = CODE_NONE;
        unique case (r_phase)
            PH_DEBOUNCE: begin
                n_age = age_adv;
                if (age_adv >= {{(AGE_W-DEB_W){1'b0}}, i_cfg.debounce_time}) begin
                    if (i_pressed) begin
                        n_phase = PH_PRESSED;
                        n_age   = '0;
                        n_fired = FIRED_NONE;
                        if (quick) begin
                            o_code = CODE_QUICK;
                        end
                    end else begin
                        // bounce: back to idle, age kept until the next press
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_PRESSED: begin
                n_age = age_adv;
                if (i_pressed) begin
                    if (i_cfg.long_enable && r_fired == FIRED_NONE &&
                        age_adv >= i_cfg.long_press_time) begin
                        n_fired = FIRED_LONG;
                        o_code  = CODE_LONG;
                    end else if (i_cfg.super_long_enable && r_fired != FIRED_SUPER &&
                                 age_adv >= i_cfg.super_long_press_time) begin
                        n_fired = FIRED_SUPER;
                        o_code  = CODE_SUPER;
                    end else begin
                        o_code = CODE_HELD;
                    end
                end else begin
                    n_phase = PH_IDLE;
                    n_age   = '0;
                    if (!quick && r_fired == FIRED_NONE) begin
                        o_code = i_cfg.short_enable ? CODE_SHORT : CODE_NOT_SHORT;
                    end
                end
            end
            default: begin
                // idle, and the unused phase code
                n_phase = PH_IDLE;
                if (i_pressed) begin
                    n_phase = PH_DEBOUNCE;
                    n_age   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_age   <= '0;
            r_fired <= FIRED_NONE;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_age   <= n_age;
            r_fired <= n_fired;
        end
    end

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_IDLE) |-> (o_code == CODE_NONE))
        else $error("idle scan gave a click");

    a_long_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_code == CODE_LONG) |=> (r_fired == FIRED_LONG && r_phase == PH_PRESSED))
        else $error("long click not recorded");

    a_quick_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_code == CODE_QUICK) |=> (r_phase == PH_PRESSED && r_age == '0))
        else $error("quick click without confirmed press");

    a_long_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_code == CODE_LONG) |-> i_cfg.long_enable)
        else $error("long click while disabled");

endmodule

// ----- tb/button_click_classifier_top_test.sv -----
// Self-checking testbench for the button click classifier top level.
module button_click_classifier_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bcc_pkg::*;

    localparam int RANDOM_SCANS   = 1500;
    localparam int RANDOM_PHASES  = 10;
    localparam int LONG_HOLD_OFF  = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_pressed   = 1'b0;
    logic [DT_W-1:0]       i_elapsed   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [CODE_W-1:0]     o_click_code;

    // Shared between the sender, the receiver and the main sequence
    int scans_sent      = 0;
    int hold_off_cycles = 0;
    bit steady          = 1'b0;

    class click_scoreboard;
        t_cfg             cfg;
        t_phase           phase;
        logic [AGE_W-1:0] age;
        t_fired           fired;
        t_code            expected_codes[$];
        int               errors;

        function new();
            cfg.debounce_time         = RST_DEBOUNCE;
            cfg.long_press_time       = RST_LONG_TIME;
            cfg.super_long_press_time = RST_SUPER_TIME;
            cfg.short_enable          = RST_SHORT_EN;
            cfg.long_enable           = RST_LONG_EN;
            cfg.super_long_enable     = RST_SUPER_EN;
            phase  = PH_IDLE;
            age    = '0;
            fired  = FIRED_NONE;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IDX_DEBOUNCE:   cfg.debounce_time         = data[DEB_W-1:0];
                CFG_IDX_LONG_TIME:  cfg.long_press_time       = data[AGE_W-1:0];
                CFG_IDX_SUPER_TIME: cfg.super_long_press_time = data[AGE_W-1:0];
                CFG_IDX_SHORT_EN:   cfg.short_enable          = data[0];
                CFG_IDX_LONG_EN:    cfg.long_enable           = data[0];
                CFG_IDX_SUPER_EN:   cfg.super_long_enable     = data[0];
                default: ;
            endcase
        endfunction

        function t_code classify_scan(logic down, logic [DT_W-1:0] dt);
            logic           quick;
            logic [AGE_W:0] sum;
            t_code          code;
            quick = cfg.short_enable && !cfg.long_enable && !cfg.super_long_enable;
            code  = CODE_NONE;
            // advance the age, saturating, in every phase but idle
            if (phase == PH_DEBOUNCE || phase == PH_PRESSED) begin
                sum = {1'b0, age} + {1'b0, dt};
                age = sum[AGE_W] ? {AGE_W{1'b1}} : sum[AGE_W-1:0];
            end
            case (phase)
                PH_DEBOUNCE: begin
                    if (age >= AGE_W'(cfg.debounce_time)) begin
                        if (down) begin
                            phase = PH_PRESSED;
                            age   = '0;
                            fired = FIRED_NONE;
                            if (quick) code = CODE_QUICK;
                        end else begin
                            // bounce: back to idle, age kept until the next press
                            phase = PH_IDLE;
                        end
                    end
                end
                PH_PRESSED: begin
                    if (down) begin
                        if (cfg.long_enable && fired < FIRED_LONG
                                && age >= cfg.long_press_time) begin
                            fired = FIRED_LONG;
                            code  = CODE_LONG;
                        end else if (cfg.super_long_enable && fired < FIRED_SUPER
                                && age >= cfg.super_long_press_time) begin
                            fired = FIRED_SUPER;
                            code  = CODE_SUPER;
                        end else begin
                            code = CODE_HELD;
                        end
                    end else begin
                        phase = PH_IDLE;
                        age   = '0;
                        if (!quick && fired == FIRED_NONE)
                            code = cfg.short_enable ? CODE_SHORT : CODE_NOT_SHORT;
                    end
                end
                default: begin
                    if (down) begin
                        phase = PH_DEBOUNCE;
                        age   = '0;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
            endcase
            return code;
        endfunction

        function void note_scan(logic down, logic [DT_W-1:0] dt);
            expected_codes.push_back(classify_scan(down, dt));
        endfunction

        function void check_code(logic [CODE_W-1:0] got);
            t_code want;
            if (expected_codes.size() == 0) begin
                $error("click_code: actual %0d with no scan outstanding", got);
                errors++;
            end else begin
                want = expected_codes.pop_front();
                if (got !== want) begin
                    $error("click_code: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    click_scoreboard clicks = new();

    button_click_classifier_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pressed    (i_pressed),
        .i_elapsed    (i_elapsed),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_click_code (o_click_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one scan word, then wait for the edge that takes it
    task automatic send_scan(input logic down, input logic [DT_W-1:0] dt);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pressed  <= down;
        i_elapsed  <= dt;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        clicks.note_scan(down, dt);
        scans_sent++;
    endtask

    // Drop valid and hold until every code is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (clicks.expected_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        clicks.set_register(idx, data);
    endtask

    task automatic apply_config(input t_cfg c);
        cfg_write(CFG_IDX_DEBOUNCE, {8'($urandom), c.debounce_time});
        cfg_write(CFG_IDX_LONG_TIME, c.long_press_time);
        cfg_write(CFG_IDX_SUPER_TIME, c.super_long_press_time);
        cfg_write(CFG_IDX_SHORT_EN, {15'($urandom), c.short_enable});
        cfg_write(CFG_IDX_LONG_EN, {15'($urandom), c.long_enable});
        cfg_write(CFG_IDX_SUPER_EN, {15'($urandom), c.super_long_enable});
        // an unused index must leave every register alone
        cfg_write(CFG_IDX_W'(CFG_IDX_SUPER_EN + 1 + $urandom_range(0, 1)), 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cfg make_cfg(logic [DEB_W-1:0] deb, logic [AGE_W-1:0] long_t,
                                      logic [AGE_W-1:0] super_t, logic short_en,
                                      logic long_en, logic super_en);
        t_cfg c;
        c.debounce_time         = deb;
        c.long_press_time       = long_t;
        c.super_long_press_time = super_t;
        c.short_enable          = short_en;
        c.long_enable           = long_en;
        c.super_long_enable     = super_en;
        return c;
    endfunction

    function automatic t_cfg random_cfg();
        logic [DEB_W-1:0] deb;
        logic [AGE_W-1:0] long_t;
        logic [AGE_W-1:0] super_t;
        deb     = ($urandom_range(0, 3) == 0) ? DEB_W'($urandom) : DEB_W'($urandom_range(0, 40));
        long_t  = ($urandom_range(0, 3) == 0) ? AGE_W'($urandom) : AGE_W'($urandom_range(0, 600));
        super_t = ($urandom_range(0, 3) == 0) ? AGE_W'($urandom) : AGE_W'($urandom_range(0, 900));
        return make_cfg(deb, long_t, super_t, 1'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    // Many short scan intervals, many scaled to the hold thresholds, a few huge
    function automatic logic [DT_W-1:0] pick_elapsed();
        int r;
        int span;
        r = $urandom_range(0, 99);
        if (r < 45)
            return DT_W'($urandom_range(0, 30));
        if (r < 75) begin
            span = int'(clicks.cfg.long_press_time) / 3 + 1;
            return DT_W'($urandom_range(0, span));
        end
        if (r < 92) begin
            span = int'(clicks.cfg.super_long_press_time) / 3 + 1;
            return DT_W'($urandom_range(0, span));
        end
        if (r < 98)
            return DT_W'($urandom);
        return {DT_W{1'b1}};
    endfunction

    task automatic random_episode();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        n    = $urandom_range(0, 2);
        repeat (n) send_scan(1'b0, pick_elapsed());
        if (kind < 75) begin
            // full press: debounce, hold, release
            n = $urandom_range(1, 14);
            repeat (n) send_scan(1'b1, pick_elapsed());
            send_scan(1'b0, pick_elapsed());
        end else if (kind < 90) begin
            // bounce: up again while still debouncing
            send_scan(1'b1, pick_elapsed());
            n = $urandom_range(1, 3);
            repeat (n) send_scan(1'b0, pick_elapsed());
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) send_scan(1'($urandom), DT_W'($urandom));
        end
    endtask

    // Result side: random stalls, and one long hold-off when asked for
    initial begin
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off_cycles != 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            clicks.check_code(o_click_code);
        end
    end

    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int   ph;
        int   target;
        t_cfg c;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, quick mode: quick click on confirm, saturating hold, bounce
        send_scan(1'b1, 16'd0);
        send_scan(1'b1, 16'd19);
        send_scan(1'b1, 16'd1);
        send_scan(1'b1, 16'hFFFF);
        send_scan(1'b1, 16'hFFFF);
        send_scan(1'b0, 16'd0);
        send_scan(1'b1, 16'd5);
        send_scan(1'b0, 16'd40);
        send_scan(1'b0, 16'hFFFF);

        // Super long first: long is then no longer fired
        wait_idle();
        apply_config(make_cfg(8'd0, 16'd300, 16'd100, 1'b1, 1'b1, 1'b1));
        send_scan(1'b1, 16'd0);
        send_scan(1'b1, 16'd0);
        send_scan(1'b1, 16'd150);
        send_scan(1'b1, 16'd200);
        send_scan(1'b0, 16'd0);

        // One slow scan past both thresholds: long now, super long next scan
        wait_idle();
        apply_config(make_cfg(8'd10, 16'd100, 16'd200, 1'b0, 1'b1, 1'b1));
        send_scan(1'b1, 16'd0);
        send_scan(1'b1, 16'd10);
        send_scan(1'b1, 16'hFFFF);
        send_scan(1'b1, 16'd0);
        send_scan(1'b0, 16'd7);

        // Release before any timed click gives a short click
        wait_idle();
        apply_config(make_cfg(8'd10, 16'd1000, 16'd2000, 1'b1, 1'b1, 1'b0));
        send_scan(1'b1, 16'd0);
        send_scan(1'b1, 16'd10);
        send_scan(1'b0, 16'd3);

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0:       c = make_cfg('0, '0, '0, 1'b0, 1'b0, 1'b0);
                1:       c = make_cfg('1, '1, '1, 1'b1, 1'b1, 1'b1);
                default: c = random_cfg();
            endcase
            apply_config(c);
            steady = (ph == 6);
            if (ph == 4)
                hold_off_cycles = LONG_HOLD_OFF;
            target = scans_sent + RANDOM_SCANS / RANDOM_PHASES;
            while (scans_sent < target) random_episode();
        end

        wait_idle();
        if (clicks.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
